/* rtl/rgb_to_hsv_converter_defines.svh */
// assertion macros shared by the rgb to hsv converter rtl
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk and idle while rst_n is low
`define RHC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_converter: check failed");

// next-cycle implication, sampled on clk and idle while rst_n is low
`define RHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_converter: check failed");

`else

`define RHC_ASSERT_IMPL(lbl, ante, cons)
`define RHC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/rgb_hsv_pkg.sv */
// shared constants, types and the divider step for the rgb to hsv converter
package rgb_hsv_pkg;

  // channel width, full-scale code stands for 1.0
  localparam int CB        = 8;
  localparam int HS_BITS   = 8;                 // 256 hue steps per sextant
  localparam int HQ_BITS   = HS_BITS + 1;       // hue quotient reaches 256
  localparam int HN_W      = CB + HS_BITS;      // hue dividend width
  localparam int SN_W      = 2 * CB;            // saturation dividend width
  localparam int HUE_W     = 11;
  localparam int NSTG      = (CB > HQ_BITS) ? CB : HQ_BITS;
  localparam int QDEPTH    = 2;

  localparam int HUE_SEXTANT = 1 << HS_BITS;
  localparam int HUE_TURN    = 6 * HUE_SEXTANT;

  localparam logic [HUE_W-1:0] HUE_BASE_RED   = HUE_W'(0);
  localparam logic [HUE_W-1:0] HUE_BASE_GREEN = HUE_W'(2 * HUE_SEXTANT);
  localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = HUE_W'(4 * HUE_SEXTANT);

  // which channel holds the maximum
  localparam logic [1:0] SEXT_RED   = 2'd0;
  localparam logic [1:0] SEXT_GREEN = 2'd1;
  localparam logic [1:0] SEXT_BLUE  = 2'd2;

  // classified pixel, front to back
  typedef struct packed {
    logic [HN_W-1:0] hue_num;   // |diff| * 256
    logic            neg;       // diff below zero
    logic [1:0]      sext;
    logic [CB-1:0]   delta;
    logic [CB-1:0]   hi;
    logic [SN_W-1:0] sat_num;   // full scale * delta
  } entry_t;

  // divider pipeline stage
  typedef struct packed {
    logic [HN_W-1:0]    hue_num;
    logic [SN_W-1:0]    sat_num;
    logic [CB-1:0]      hue_rem;
    logic [HQ_BITS-1:0] hue_q;
    logic [CB-1:0]      sat_rem;
    logic [CB-1:0]      sat_q;
    logic               neg;
    logic [1:0]         sext;
    logic [CB-1:0]      delta;
    logic [CB-1:0]      hi;
  } stage_t;

  // one restoring division step: returns quotient bit and new remainder
  function automatic logic [CB:0] div_step(input logic [CB-1:0] rem,
                                           input logic          bit_in,
                                           input logic [CB-1:0] den);
    logic [CB:0] sh;
    logic [CB:0] dif;
    sh  = {rem, bit_in};
    dif = sh - {1'b0, den};
    if (sh >= {1'b0, den}) begin
      return {1'b1, dif[CB-1:0]};
    end
    return {1'b0, sh[CB-1:0]};
  endfunction

endpackage

/* rtl/rgb_hsv_pix_if.sv */
// pixel channel: valid, ready and three colour channels
interface rgb_hsv_pix_if
  import rgb_hsv_pkg::*;
;
  logic          valid;
  logic          ready;
  logic [CB-1:0] red;
  logic [CB-1:0] green;
  logic [CB-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* rtl/rgb_hsv_res_if.sv */
// result channel: valid, ready, hue, saturation and brightness
interface rgb_hsv_res_if
  import rgb_hsv_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [CB-1:0]    saturation;
  logic [CB-1:0]    brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

/* rtl/rgb_to_hsv_converter.sv */
// top level of the rgb to hsv pixel converter
//
// in_pix carries one pixel per transaction (red, green, blue, full-scale code
// is intensity 1.0); out_res returns hue (1536 steps per turn, 0 is red),
// saturation and brightness (the largest channel), one result per pixel, in order.
// a transaction completes on a rising clk edge with valid and ready both high.
// throughput: one pixel per clock sustained while out_res.ready stays high, set by
// the divider pipeline, which retires one hue quotient bit per stage and, after the
// first stage, one saturation bit in parallel. a pixel passes the front register,
// a queue slot, the divider init stage, nine divider stages and the result register.
// reset (rst_n low at a clk edge) empties the front register, the queue and
// the pipeline; results in flight are dropped, only the data registers keep stale values.
// while a result waits in the result register with out_res.ready low, the result
// register and the divider pipeline freeze, the front keeps filling the two-entry
// queue, and in_pix.ready falls once the queue and front register are full.
module rgb_to_hsv_converter
  import rgb_hsv_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  rgb_hsv_pix_if.sink   in_pix,
  rgb_hsv_res_if.source out_res
);

  // front end to queue
  logic   fq_valid;
  logic   fq_ready;
  entry_t fq_ent;

  // queue to divider pipeline
  logic   qb_valid;
  logic   qb_ready;
  entry_t qb_ent;

  // classify pixel: max, min, sextant, dividends
  rgb_hsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .ent_valid (fq_valid),
    .ent_ready (fq_ready),
    .ent       (fq_ent)
  );

  // decouples the front stall from the pipeline stall
  rgb_hsv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_ent    (fq_ent),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_ent   (qb_ent)
  );

  // both divisions and final hue assembly
  rgb_hsv_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (qb_valid),
    .in_ready (qb_ready),
    .in_ent   (qb_ent),
    .out_res  (out_res)
  );

endmodule

/* rtl/rgb_hsv_front.sv */
// front end: accepts pixels, finds max, min and sextant, forms the dividends
module rgb_hsv_front
  import rgb_hsv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  rgb_hsv_pix_if.sink       in_pix,
  output logic              ent_valid,
  input  logic              ent_ready,
  output entry_t            ent
);

  logic          v_r;
  entry_t        ent_r;
  entry_t        ent_nxt;
  logic          take;
  logic [CB-1:0] r;
  logic [CB-1:0] g;
  logic [CB-1:0] b;
  logic [CB-1:0] lo;
  logic [CB-1:0] p;
  logic [CB-1:0] m;

  assign in_pix.ready = !v_r || ent_ready;
  assign take         = in_pix.valid && in_pix.ready;
  assign r            = in_pix.red;
  assign g            = in_pix.green;
  assign b            = in_pix.blue;

  always_comb begin
    ent_nxt = '0;
    if (r >= g && r >= b) begin
      ent_nxt.sext = SEXT_RED;
      ent_nxt.hi   = r;
      p            = g;
      m            = b;
    end else if (g >= b) begin
      ent_nxt.sext = SEXT_GREEN;
      ent_nxt.hi   = g;
      p            = b;
      m            = r;
    end else begin
      ent_nxt.sext = SEXT_BLUE;
      ent_nxt.hi   = b;
      p            = r;
      m            = g;
    end
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    ent_nxt.delta   = ent_nxt.hi - lo;
    ent_nxt.neg     = p < m;
    ent_nxt.hue_num = {(ent_nxt.neg ? (m - p) : (p - m)), HS_BITS'(0)};
    // full scale times delta is delta shifted up less delta
    ent_nxt.sat_num = {ent_nxt.delta, CB'(0)} - {CB'(0), ent_nxt.delta};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_pix.ready) begin
      v_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent_r <= ent_nxt;
    end
  end

  assign ent_valid = v_r;
  assign ent       = ent_r;

endmodule

/* rtl/rgb_hsv_queue.sv */
// short queue between the front end and the divider pipeline
module rgb_hsv_queue
  import rgb_hsv_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  entry_t in_ent,
  output logic   out_valid,
  input  logic   out_ready,
  output entry_t out_ent
);
`include "rgb_to_hsv_converter_defines.svh"

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  entry_t        mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          push;
  logic          pop;

  assign in_ready  = cnt_r != CW'(QDEPTH);
  assign out_valid = cnt_r != '0;
  assign out_ent   = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_ent;
    end
  end

  `RHC_ASSERT_IMPL(a_q_cnt_bound, 1'b1, cnt_r <= CW'(QDEPTH))
  `RHC_ASSERT_NEXT(a_q_fill, push && !pop, cnt_r == $past(cnt_r) + CW'(1))
  `RHC_ASSERT_NEXT(a_q_drain, pop && !push, cnt_r == $past(cnt_r) - CW'(1))

endmodule

/* rtl/rgb_hsv_back.sv */
// back end: pipelined restoring dividers for hue and saturation, result register
module rgb_hsv_back
  import rgb_hsv_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  entry_t        in_ent,
  rgb_hsv_res_if.source out_res
);
`include "rgb_to_hsv_converter_defines.svh"

  stage_t           stg_r [NSTG+1];
  logic [NSTG:0]    vld_r;
  logic             out_valid_r;
  logic [HUE_W-1:0] hue_r;
  logic [CB-1:0]    sat_r;
  logic [CB-1:0]    bright_r;
  logic             adv;
  stage_t           init;
  stage_t           last;
  logic [HUE_W-1:0] base;
  logic [HQ_BITS:0] mag;
  logic signed [HUE_W:0] h_sum;
  logic [HUE_W-1:0] hue_nxt;

  // whole pipeline moves when the result register is free or being taken
  assign adv      = !out_valid_r || out_res.ready;
  assign in_ready = adv;

  always_comb begin
    init         = '0;
    init.hue_num = in_ent.hue_num;
    init.sat_num = in_ent.sat_num;
    init.hue_rem = CB'(in_ent.hue_num >> HQ_BITS);
    init.sat_rem = in_ent.sat_num[SN_W-1:CB];
    init.neg     = in_ent.neg;
    init.sext    = in_ent.sext;
    init.delta   = in_ent.delta;
    init.hi      = in_ent.hi;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r[0] <= init;
    end
  end

  // one quotient bit per stage and division, msb first; saturation idles in the first stage
  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    localparam int K = NSTG - 1 - s;
    logic [CB:0] h_step;
    logic [CB:0] s_step;
    stage_t      nxt;

    if (K < HQ_BITS) begin : g_hue
      assign h_step = div_step(stg_r[s].hue_rem, stg_r[s].hue_num[K], stg_r[s].delta);
    end else begin : g_hue_idle
      assign h_step = {1'b0, stg_r[s].hue_rem};
    end

    if (K < CB) begin : g_sat
      assign s_step = div_step(stg_r[s].sat_rem, stg_r[s].sat_num[K], stg_r[s].hi);
    end else begin : g_sat_idle
      assign s_step = {1'b0, stg_r[s].sat_rem};
    end

    always_comb begin
      nxt         = stg_r[s];
      nxt.hue_rem = h_step[CB-1:0];
      nxt.sat_rem = s_step[CB-1:0];
      if (K < HQ_BITS) begin
        nxt.hue_q = {stg_r[s].hue_q[HQ_BITS-2:0], h_step[CB]};
      end
      if (K < CB) begin
        nxt.sat_q = {stg_r[s].sat_q[CB-2:0], s_step[CB]};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[s+1] <= nxt;
      end
    end
  end

  // floor of a negative quotient steps one further down when there is a remainder
  assign last = stg_r[NSTG];

  always_comb begin
    case (last.sext)
      SEXT_GREEN: base = HUE_BASE_GREEN;
      SEXT_BLUE:  base = HUE_BASE_BLUE;
      default:    base = HUE_BASE_RED;
    endcase
    mag = {1'b0, last.hue_q};
    if (last.neg && last.hue_rem != '0) begin
      mag = mag + (HQ_BITS+1)'(1);
    end
    if (last.neg) begin
      h_sum = $signed({1'b0, base}) - $signed((HUE_W+1)'(mag));
    end else begin
      h_sum = $signed({1'b0, base}) + $signed((HUE_W+1)'(mag));
    end
    if (h_sum < 0) begin
      h_sum = h_sum + $signed((HUE_W+1)'(HUE_TURN));
    end
    hue_nxt = (last.delta == '0) ? '0 : h_sum[HUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-1:0], in_valid};
      out_valid_r <= vld_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue_r    <= hue_nxt;
      sat_r    <= (last.hi == '0) ? '0 : last.sat_q;
      bright_r <= last.hi;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.hue        = hue_r;
  assign out_res.saturation = sat_r;
  assign out_res.brightness = bright_r;

  `RHC_ASSERT_IMPL(a_hue_range, out_valid_r, hue_r < HUE_W'(HUE_TURN))
  `RHC_ASSERT_IMPL(a_black_sat, out_valid_r && bright_r == '0, sat_r == '0)
  `RHC_ASSERT_NEXT(a_pipe_hold, out_valid_r && !out_res.ready, $stable(vld_r))

endmodule

/* tb/tb_rgb_to_hsv_converter.sv */
// self-checking testbench for the rgb to hsv pixel converter
`timescale 1ns / 100ps

module tb_rgb_to_hsv_converter;
  import rgb_hsv_pkg::*;

  // full-scale channel code, stands for intensity 1.0
  localparam int FULL_SCALE  = (1 << CB) - 1;
  localparam int RAND_PIXELS = 500;
  localparam int N_DIRECTED  = 22;
  // front register, queue slot, divider init, nine stages, result register
  localparam int PIPE_LATENCY = 12;
  // worst case per pixel is an idle gap, a stall and the latency; ample margin
  localparam int CYCLE_LIMIT  = 200000;

  // one converted pixel, as it appears on the result channel
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CB-1:0]    saturation;
    logic [CB-1:0]    brightness;
  } hsv_t;

  // directed stimulus row; known marks a result typed in by hand
  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
    logic          known;
    hsv_t          want;
  } pixel_row_t;

  logic clk;
  logic rst_n;

  rgb_hsv_pix_if pix_if ();
  rgb_hsv_res_if res_if ();

  rgb_to_hsv_converter DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_if),
    .out_res (res_if)
  );

  // results still owed by the converter, oldest first
  hsv_t hsv_expected_q[$];
  int   error_count;
  int   cycle_count;

  // travels with the pixel on the input channel, sampled at its acceptance
  logic pix_known;
  hsv_t pix_want;

  pixel_row_t directed_rows [N_DIRECTED];

  // floor division for a positive divisor and a dividend of either sign
  function automatic int floor_quot(input int num, input int den);
    if (num >= 0) begin
      return num / den;
    end
    return -((-num + den - 1) / den);
  endfunction

  // integer hsv of one pixel: hue in 1536 steps, ties go red then green
  function automatic hsv_t hsv_of_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                                        input logic [CB-1:0] b);
    int   ri;
    int   gi;
    int   bi;
    int   hi;
    int   lo;
    int   delta;
    int   hue;
    hsv_t res;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    hi = ri;
    lo = ri;
    if (gi > hi) hi = gi;
    if (bi > hi) hi = bi;
    if (gi < lo) lo = gi;
    if (bi < lo) lo = bi;
    delta = hi - lo;
    hue   = 0;
    // gray (and black) leaves hue at zero
    if (delta != 0) begin
      if (hi == ri) begin
        hue = floor_quot(HUE_SEXTANT * (gi - bi), delta);
        hue = (hue + HUE_TURN) % HUE_TURN;
      end else if (hi == gi) begin
        hue = 2 * HUE_SEXTANT + floor_quot(HUE_SEXTANT * (bi - ri), delta);
      end else begin
        hue = 4 * HUE_SEXTANT + floor_quot(HUE_SEXTANT * (ri - gi), delta);
      end
    end
    res.hue        = HUE_W'(hue);
    res.saturation = (hi == 0) ? '0 : CB'((FULL_SCALE * delta) / hi);
    res.brightness = CB'(hi);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want);
    error_count++;
  endtask

  // clock, 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // input monitor: every accepted pixel transaction queues its expected result
  always @(posedge clk) begin
    if (rst_n && pix_if.valid && pix_if.ready) begin
      if (pix_known) begin
        hsv_expected_q.push_back(pix_want);
      end else begin
        hsv_expected_q.push_back(hsv_of_pixel(pix_if.red, pix_if.green, pix_if.blue));
      end
    end
  end

  // output monitor: each result transaction is compared with the oldest expectation
  always @(posedge clk) begin
    hsv_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (hsv_expected_q.size() == 0) begin
        $display("%0t: result with nothing outstanding, hue %0d sat %0d val %0d", $time,
                 res_if.hue, res_if.saturation, res_if.brightness);
        error_count++;
      end else begin
        want = hsv_expected_q.pop_front();
        if (res_if.hue !== want.hue)
          report_mismatch("hue", res_if.hue, want.hue);
        if (res_if.saturation !== want.saturation)
          report_mismatch("saturation", res_if.saturation, want.saturation);
        if (res_if.brightness !== want.brightness)
          report_mismatch("brightness", res_if.brightness, want.brightness);
      end
    end
  end

  // result receiver: random back-pressure with occasional stretches of none
  initial begin
    int  stall;
    int  taken;
    bit  rx_steady;
    res_if.ready <= 1'b0;
    taken     = 0;
    rx_steady = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 37 == 0) rx_steady = ($urandom_range(0, 2) == 0);
      stall = rx_steady ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      // ready is high here, so a valid at the edge is a completed transaction
      do @(posedge clk); while (!res_if.valid);
      taken++;
    end
  end

  // present one pixel after an idle gap and hold it until the transaction completes;
  // with no gap valid simply stays high into the next pixel
  task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                            input logic [CB-1:0] b, input logic known, input hsv_t want,
                            input int gap);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= r;
    pix_if.green <= g;
    pix_if.blue  <= b;
    pix_known    <= known;
    pix_want     <= want;
    do @(posedge clk); while (!pix_if.ready);
  endtask

  // hold the input idle until every outstanding result has come back
  task automatic wait_for_drain();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (hsv_expected_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [CB-1:0] r;
    logic [CB-1:0] g;
    logic [CB-1:0] b;
    logic [CB-1:0] v;
    int            gap;
    bit            tx_steady;

    rst_n        <= 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.red   <= '0;
    pix_if.green <= '0;
    pix_if.blue  <= '0;
    pix_known    <= 1'b0;
    pix_want     <= '0;

    // hand-typed results only for primaries, secondaries, grays and extremes
    directed_rows = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, '{11'd0,    8'd0,   8'd0}},    // black
      '{8'd255, 8'd255, 8'd255, 1'b1, '{11'd0,    8'd0,   8'd255}},  // white
      '{8'd128, 8'd128, 8'd128, 1'b1, '{11'd0,    8'd0,   8'd128}},  // mid gray
      '{8'd1,   8'd1,   8'd1,   1'b1, '{11'd0,    8'd0,   8'd1}},    // darkest gray
      '{8'd255, 8'd0,   8'd0,   1'b1, '{11'd0,    8'd255, 8'd255}},  // red
      '{8'd0,   8'd255, 8'd0,   1'b1, '{11'd512,  8'd255, 8'd255}},  // green
      '{8'd0,   8'd0,   8'd255, 1'b1, '{11'd1024, 8'd255, 8'd255}},  // blue
      '{8'd255, 8'd255, 8'd0,   1'b1, '{11'd256,  8'd255, 8'd255}},  // yellow, red wins tie
      '{8'd0,   8'd255, 8'd255, 1'b1, '{11'd768,  8'd255, 8'd255}},  // cyan, green wins tie
      '{8'd255, 8'd0,   8'd255, 1'b1, '{11'd1280, 8'd255, 8'd255}},  // magenta, red wins tie
      '{8'd1,   8'd0,   8'd0,   1'b1, '{11'd0,    8'd255, 8'd1}},    // faintest red
      '{8'd0,   8'd0,   8'd1,   1'b1, '{11'd1024, 8'd255, 8'd1}},    // faintest blue
      '{8'd255, 8'd0,   8'd1,   1'b0, '0},  // hue wraps just below a full turn
      '{8'd255, 8'd1,   8'd0,   1'b0, '0},
      '{8'd200, 8'd200, 8'd50,  1'b0, '0},  // red and green tie
      '{8'd10,  8'd180, 8'd180, 1'b0, '0},  // green and blue tie
      '{8'd90,  8'd20,  8'd90,  1'b0, '0},  // red and blue tie
      '{8'd0,   8'd255, 8'd254, 1'b0, '0},
      '{8'd254, 8'd0,   8'd255, 1'b0, '0},
      '{8'd255, 8'd254, 8'd254, 1'b0, '0},  // barely saturated
      '{8'd1,   8'd255, 8'd0,   1'b0, '0},
      '{8'd170, 8'd85,  8'd0,   1'b0, '0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, mostly back to back
    foreach (directed_rows[i]) begin
      gap = (i % 4 == 3) ? $urandom_range(1, 12) : 0;
      send_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                 directed_rows[i].known, directed_rows[i].want, gap);
    end

    // let the pipeline empty completely before the random part
    wait_for_drain();

    tx_steady = 1'b0;
    for (int i = 0; i < RAND_PIXELS; i++) begin
      if (i % 40 == 0) tx_steady = ($urandom_range(0, 2) == 0);
      // second full drain half way through
      if (i == RAND_PIXELS / 2) wait_for_drain();
      r = CB'($urandom);
      g = CB'($urandom);
      b = CB'($urandom);
      case ($urandom_range(0, 9)) inside
        5: begin
          // gray
          g = r;
          b = r;
        end
        [6:7]: begin
          // two channels share the maximum
          v = CB'($urandom_range(1, FULL_SCALE));
          case ($urandom_range(0, 2))
            0: begin r = v; g = v; b = CB'($urandom_range(0, v)); end
            1: begin g = v; b = v; r = CB'($urandom_range(0, v)); end
            default: begin r = v; b = v; g = CB'($urandom_range(0, v)); end
          endcase
        end
        8: begin
          // channels pinned to the ends of the range
          if ($urandom_range(0, 2) == 0) r = '0; else if ($urandom_range(0, 1)) r = '1;
          if ($urandom_range(0, 2) == 0) g = '0; else if ($urandom_range(0, 1)) g = '1;
          if ($urandom_range(0, 2) == 0) b = '0; else if ($urandom_range(0, 1)) b = '1;
        end
        9: begin
          // tiny values, small deltas stress the divider
          r = CB'($urandom_range(0, 3));
          g = CB'($urandom_range(0, 3));
          b = CB'($urandom_range(0, 3));
        end
        default: ;
      endcase
      gap = tx_steady ? 0 : $urandom_range(0, 12);
      send_pixel(r, g, b, 1'b0, '0, gap);
    end

    // all pixels in: wait for the tail, then allow for any stray result
    wait_for_drain();
    repeat (PIPE_LATENCY + 8) @(posedge clk);

    if (error_count == 0 && hsv_expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/rgb_hsv_pkg.sv
rtl/rgb_hsv_pix_if.sv
rtl/rgb_hsv_res_if.sv
rtl/rgb_hsv_front.sv
rtl/rgb_hsv_queue.sv
rtl/rgb_hsv_back.sv
rtl/rgb_to_hsv_converter.sv
tb/tb_rgb_to_hsv_converter.sv
